// File: src/opl_pkg.sv
// Shared types and constants for the order price level queue.
// No dependencies; imported by the top level and the testbench.
package opl_pkg;

	localparam int OPL_ORDER_SLOTS = 1024;
	localparam int SLOT_W = 10;
	localparam int QTY_W = 31;
	localparam int STATUS_W = 3;
	localparam int COUNT_W = 11;

	localparam logic [QTY_W-1:0] QTY_MAX = {QTY_W{1'b1}};

	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_REDUCE = 2'd3;

	localparam logic [STATUS_W-1:0] STS_OK = 3'd0;
	localparam logic [STATUS_W-1:0] STS_BAD_QTY = 3'd1;
	localparam logic [STATUS_W-1:0] STS_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] STS_EMPTY = 3'd3;
	localparam logic [STATUS_W-1:0] STS_LINK = 3'd4;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} opl_state_t;

	typedef struct packed {
		logic [1:0] command;
		logic [SLOT_W-1:0] order_slot;
		logic [QTY_W-1:0] quantity;
	} opl_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0] popped_slot;
		logic [QTY_W-1:0] popped_qty;
		logic [QTY_W-1:0] open_qty;
		logic [COUNT_W-1:0] open_orders;
	} opl_rsp_t;

endpackage

// File: src/opl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module opl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/order_price_level_fifo.sv
// One price level of an order book: a time-priority doubly linked queue.
// Each command word is handled in two states: the accept cycle issues the RAM reads,
// then S_EXEC evaluates and writes back; the result and done strobe are registered from S_EXEC.
// A new command is not accepted while one is in S_EXEC (busy high): the RAM is read, then written.
// After reset the linked flags are swept clear slot by slot in S_CLEAR (busy high).
// Depends on opl_pkg and opl_ram.
module order_price_level_fifo
	import opl_pkg::*;
#(
	parameter int ORDER_SLOTS = OPL_ORDER_SLOTS
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input opl_req_t request,
	output logic busy,
	output logic done,
	output opl_rsp_t result
);

	localparam int AW = $clog2(ORDER_SLOTS);
	localparam int LW = $clog2(ORDER_SLOTS + 1);
	localparam int XW = (AW > SLOT_W) ? AW : SLOT_W;
	localparam logic [LW-1:0] NULL_LINK = LW'(ORDER_SLOTS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(ORDER_SLOTS - 1);

	opl_state_t state_q, state_d;

	logic [LW-1:0] head_q, head_d, tail_q, tail_d;
	logic [QTY_W-1:0] total_q, total_d;
	logic [LW-1:0] count_q, count_d;
	logic [AW-1:0] clr_q, clr_d;
	logic done_q, done_d;
	opl_rsp_t result_q, result_d;

	logic [1:0] cmd_s1;
	logic [AW-1:0] addr_s1;
	logic inrange_s1;
	logic [QTY_W-1:0] qty_s1;

	logic [XW-1:0] slot_x;
	logic req_inrange;
	logic [AW-1:0] rd_addr;
	logic accept;

	logic flag_rd;
	logic [LW-1:0] prev_rd, next_rd;
	logic [QTY_W-1:0] rem_rd;

	logic flag_we, flag_wdata;
	logic [AW-1:0] flag_waddr;
	logic prev_we, next_we, rem_we;
	logic [AW-1:0] prev_waddr, next_waddr, rem_waddr;
	logic [LW-1:0] prev_wdata, next_wdata;
	logic [QTY_W-1:0] rem_wdata;

	logic [LW-1:0] s_link, p_link, n_link;
	logic linked, do_unlink;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done = done_q;
	assign result = result_q;

	assign slot_x = XW'(request.order_slot);
	assign req_inrange = (32'(request.order_slot) < 32'(ORDER_SLOTS));
	// pop addresses the head; everything else the given slot
	assign rd_addr = (request.command == CMD_POP) ? head_q[AW-1:0] : slot_x[AW-1:0];

	opl_ram #(.WIDTH(1), .DEPTH(ORDER_SLOTS)) u_flag_ram (
		.clk(clk), .we(flag_we), .waddr(flag_waddr), .wdata(flag_wdata),
		.raddr(rd_addr), .rdata(flag_rd)
	);

	opl_ram #(.WIDTH(LW), .DEPTH(ORDER_SLOTS)) u_prev_ram (
		.clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
		.raddr(rd_addr), .rdata(prev_rd)
	);

	opl_ram #(.WIDTH(LW), .DEPTH(ORDER_SLOTS)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.raddr(rd_addr), .rdata(next_rd)
	);

	opl_ram #(.WIDTH(QTY_W), .DEPTH(ORDER_SLOTS)) u_rem_ram (
		.clk(clk), .we(rem_we), .waddr(rem_waddr), .wdata(rem_wdata),
		.raddr(rd_addr), .rdata(rem_rd)
	);

	// Push leaves the new tail's next unwritten; the queue ends are derived here.
	assign s_link = LW'(addr_s1);
	assign p_link = (s_link == head_q) ? NULL_LINK : prev_rd;
	assign n_link = (s_link == tail_q) ? NULL_LINK : next_rd;
	assign linked = inrange_s1 && flag_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			head_q <= NULL_LINK;
			tail_q <= NULL_LINK;
			total_q <= '0;
			count_q <= '0;
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			tail_q <= tail_d;
			total_q <= total_d;
			count_q <= count_d;
			clr_q <= clr_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
		if (accept) begin
			cmd_s1 <= request.command;
			addr_s1 <= rd_addr;
			inrange_s1 <= req_inrange;
			qty_s1 <= request.quantity;
		end
	end

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		tail_d = tail_q;
		total_d = total_q;
		count_d = count_q;
		clr_d = clr_q;
		done_d = 1'b0;
		result_d = result_q;
		do_unlink = 1'b0;

		flag_we = 1'b0;
		flag_waddr = addr_s1;
		flag_wdata = 1'b0;
		prev_we = 1'b0;
		prev_waddr = addr_s1;
		prev_wdata = tail_q;
		next_we = 1'b0;
		next_waddr = tail_q[AW-1:0];
		next_wdata = s_link;
		rem_we = 1'b0;
		rem_waddr = addr_s1;
		rem_wdata = qty_s1;

		result_d.status = STS_OK;
		result_d.popped_slot = '0;
		result_d.popped_qty = '0;

		unique case (state_q)
			S_CLEAR: begin
				flag_we = 1'b1;
				flag_waddr = clr_q;
				clr_d = clr_q + 1'b1;
				if (clr_q == LAST_ADDR) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				done_d = 1'b1;
				unique case (cmd_s1)
					CMD_PUSH: begin
						if (qty_s1 == '0) begin
							result_d.status = STS_BAD_QTY;
						end else if (qty_s1 > (QTY_MAX - total_q)) begin
							result_d.status = STS_FULL;
						end else if (!inrange_s1 || flag_rd) begin
							result_d.status = STS_LINK;
						end else begin
							prev_we = 1'b1;
							if (tail_q != NULL_LINK) begin
								next_we = 1'b1;
							end else begin
								head_d = s_link;
							end
							tail_d = s_link;
							rem_we = 1'b1;
							flag_we = 1'b1;
							flag_wdata = 1'b1;
							total_d = total_q + qty_s1;
							count_d = count_q + 1'b1;
						end
					end
					CMD_POP: begin
						if (head_q == NULL_LINK || count_q == '0) begin
							result_d.status = STS_EMPTY;
						end else begin
							result_d.popped_slot = SLOT_W'(addr_s1);
							result_d.popped_qty = rem_rd;
							do_unlink = 1'b1;
						end
					end
					CMD_REMOVE: begin
						if (!linked) begin
							result_d.status = STS_LINK;
						end else begin
							do_unlink = 1'b1;
						end
					end
					CMD_REDUCE: begin
						if (!linked) begin
							result_d.status = STS_LINK;
						end else if (qty_s1 == '0 || qty_s1 >= rem_rd) begin
							result_d.status = STS_BAD_QTY;
						end else begin
							rem_we = 1'b1;
							rem_wdata = rem_rd - qty_s1;
							total_d = total_q - qty_s1;
						end
					end
					default: begin
						result_d.status = STS_OK;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// splice the addressed word out of the queue
		if (do_unlink) begin
			if (p_link != NULL_LINK) begin
				next_we = 1'b1;
				next_waddr = p_link[AW-1:0];
				next_wdata = n_link;
			end else begin
				head_d = n_link;
			end
			if (n_link != NULL_LINK) begin
				prev_we = 1'b1;
				prev_waddr = n_link[AW-1:0];
				prev_wdata = p_link;
			end else begin
				tail_d = p_link;
			end
			flag_we = 1'b1;
			flag_wdata = 1'b0;
			total_d = total_q - rem_rd;
			if (count_q != '0) begin
				count_d = count_q - 1'b1;
			end
		end

		result_d.open_qty = total_d;
		result_d.open_orders = COUNT_W'(count_d);
	end

endmodule

// File: tb/opl_level_checker.sv
// Checker for the order price level queue: watches the command and result words,
// keeps its own copy of the level and compares every result field by field.
// Depends on opl_pkg.
`timescale 1ns / 100ps

module opl_level_checker
	import opl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input opl_req_t request,
	input logic done,
	input opl_rsp_t result,
	output int errors,
	output int outstanding
);

	localparam logic [COUNT_W-1:0] NO_SLOT = COUNT_W'(OPL_ORDER_SLOTS);
	localparam logic [31:0] QTY_MASK = {1'b0, QTY_MAX};

	logic [COUNT_W-1:0] link_prev [OPL_ORDER_SLOTS];
	logic [COUNT_W-1:0] link_next [OPL_ORDER_SLOTS];
	logic [QTY_W-1:0] remaining_qty [OPL_ORDER_SLOTS];
	logic queued [OPL_ORDER_SLOTS];
	logic [COUNT_W-1:0] head_order;
	logic [COUNT_W-1:0] tail_order;
	logic [31:0] level_qty;
	logic [COUNT_W-1:0] level_orders;

	opl_rsp_t expected_results [$];
	int mismatches = 0;

	function automatic void clear_level();
		for (int i = 0; i < OPL_ORDER_SLOTS; i++)
			queued[i] = 1'b0;
		head_order = NO_SLOT;
		tail_order = NO_SLOT;
		level_qty = '0;
		level_orders = '0;
	endfunction

	function automatic void unlink_order(logic [SLOT_W-1:0] s);
		logic [COUNT_W-1:0] p;
		logic [COUNT_W-1:0] n;
		p = link_prev[s];
		n = link_next[s];
		if (p < NO_SLOT)
			link_next[p[SLOT_W-1:0]] = n;
		else
			head_order = n;
		if (n < NO_SLOT)
			link_prev[n[SLOT_W-1:0]] = p;
		else
			tail_order = p;
		link_prev[s] = NO_SLOT;
		link_next[s] = NO_SLOT;
		queued[s] = 1'b0;
		level_qty = (level_qty - {1'b0, remaining_qty[s]}) & QTY_MASK;
		if (level_orders != 0)
			level_orders = level_orders - 1'b1;
	endfunction

	// applies one command word to the shadow level and returns the result word
	function automatic opl_rsp_t run_command(opl_req_t w);
		opl_rsp_t r;
		logic [SLOT_W-1:0] s;
		logic [QTY_W-1:0] q;
		r = '0;
		r.status = STS_OK;
		s = w.order_slot;
		q = w.quantity;
		case (w.command)
			CMD_PUSH: begin
				if (q == 0)
					r.status = STS_BAD_QTY;
				else if ({1'b0, q} > QTY_MASK - level_qty)
					r.status = STS_FULL;
				else if (queued[s])
					r.status = STS_LINK;
				else begin
					link_prev[s] = tail_order;
					link_next[s] = NO_SLOT;
					if (tail_order < NO_SLOT)
						link_next[tail_order[SLOT_W-1:0]] = {1'b0, s};
					else
						head_order = {1'b0, s};
					tail_order = {1'b0, s};
					remaining_qty[s] = q;
					queued[s] = 1'b1;
					level_qty = level_qty + {1'b0, q};
					level_orders = level_orders + 1'b1;
				end
			end
			CMD_POP: begin
				if (head_order >= NO_SLOT || level_orders == 0)
					r.status = STS_EMPTY;
				else begin
					r.popped_slot = head_order[SLOT_W-1:0];
					r.popped_qty = remaining_qty[head_order[SLOT_W-1:0]];
					unlink_order(head_order[SLOT_W-1:0]);
				end
			end
			CMD_REMOVE: begin
				if (!queued[s])
					r.status = STS_LINK;
				else
					unlink_order(s);
			end
			CMD_REDUCE: begin
				if (!queued[s])
					r.status = STS_LINK;
				else if (q == 0 || q >= remaining_qty[s])
					r.status = STS_BAD_QTY;
				else begin
					remaining_qty[s] = remaining_qty[s] - q;
					level_qty = (level_qty - {1'b0, q}) & QTY_MASK;
				end
			end
			default: ;
		endcase
		r.open_qty = level_qty[QTY_W-1:0];
		r.open_orders = level_orders;
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		opl_rsp_t want;
		if (!arst_n) begin
			clear_level();
			expected_results.delete();
			outstanding <= 0;
			errors <= mismatches;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result word with none expected: expected none, actual %h",
						$time, result);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", 32'(want.status), 32'(result.status));
					check_field("popped_slot", 32'(want.popped_slot), 32'(result.popped_slot));
					check_field("popped_qty", 32'(want.popped_qty), 32'(result.popped_qty));
					check_field("open_qty", 32'(want.open_qty), 32'(result.open_qty));
					check_field("open_orders", 32'(want.open_orders), 32'(result.open_orders));
				end
			end
			if (start && !busy)
				expected_results.push_back(run_command(request));
			outstanding <= expected_results.size();
			errors <= mismatches;
		end
	end

endmodule

// File: tb/tb_top.sv
// Top of the order price level queue testbench: clock, reset, command stimulus
// and verdict. Depends on opl_pkg, order_price_level_fifo and opl_level_checker.
`timescale 1ns / 100ps

module tb_top;
	import opl_pkg::*;

	localparam int RANDOM_WORDS = 1200;
	localparam int PHASE_WORDS = 100;
	localparam int CYCLE_LIMIT = 400000;

	localparam int MODE_GROW = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;
	localparam int MODE_DEEP = 3;

	logic clk;
	logic arst_n;
	logic start;
	opl_req_t request;
	logic busy;
	logic done;
	opl_rsp_t result;
	int errors;
	int outstanding;
	int cycle_count = 0;

	bit quiet_phase = 1'b0;
	int phase_mode = MODE_MIXED;
	int window_base = 0;
	int window_span = 32;

	order_price_level_fifo i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result)
	);

	opl_level_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.errors(errors),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// start stays high across back-to-back words; it drops only for a gap
	task automatic send_word(logic [1:0] cmd, logic [SLOT_W-1:0] slot, logic [QTY_W-1:0] qty);
		int gap;
		start <= 1'b1;
		request <= '{command: cmd, order_slot: slot, quantity: qty};
		do @(posedge clk); while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [SLOT_W-1:0] pick_slot();
		if ($urandom_range(0, 9) < 7)
			return SLOT_W'(window_base + $urandom_range(0, window_span - 1));
		else
			return SLOT_W'($urandom_range(0, OPL_ORDER_SLOTS - 1));
	endfunction

	function automatic logic [QTY_W-1:0] pick_qty();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		else if (r < 55)
			return QTY_W'($urandom_range(1, 1000));
		else if (r < 80)
			return QTY_W'($urandom_range(1, 1 << 20));
		else if (r < 93)
			return QTY_MAX - QTY_W'($urandom_range(0, 2000));
		else
			return QTY_W'($urandom);
	endfunction

	function automatic logic [1:0] pick_command();
		int r;
		r = $urandom_range(0, 99);
		case (phase_mode)
			MODE_GROW, MODE_DEEP: begin
				if (r < 60) return CMD_PUSH;
				else if (r < 68) return CMD_POP;
				else if (r < 82) return CMD_REMOVE;
				else return CMD_REDUCE;
			end
			MODE_DRAIN: begin
				if (r < 15) return CMD_PUSH;
				else if (r < 60) return CMD_POP;
				else if (r < 85) return CMD_REMOVE;
				else return CMD_REDUCE;
			end
			default: begin
				if (r < 35) return CMD_PUSH;
				else if (r < 55) return CMD_POP;
				else if (r < 75) return CMD_REMOVE;
				else return CMD_REDUCE;
			end
		endcase
	endfunction

	initial begin
		start <= 1'b0;
		request <= '0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty pop, quantity limits, link errors, unlink at head, middle and tail
		send_word(CMD_POP, 10'd0, '0);
		send_word(CMD_PUSH, 10'd0, '0);
		send_word(CMD_PUSH, 10'd0, 31'd1);
		send_word(CMD_PUSH, 10'd0, 31'd5);
		send_word(CMD_PUSH, 10'd1023, QTY_MAX - 31'd1);
		send_word(CMD_PUSH, 10'd5, 31'd1);
		send_word(CMD_REDUCE, 10'd1023, '0);
		send_word(CMD_REDUCE, 10'd1023, QTY_MAX - 31'd1);
		send_word(CMD_REDUCE, 10'd1023, QTY_MAX);
		send_word(CMD_REDUCE, 10'd1023, QTY_MAX - 31'd2);
		send_word(CMD_REDUCE, 10'd7, 31'd3);
		send_word(CMD_REMOVE, 10'd7, '0);
		send_word(CMD_PUSH, 10'd512, 31'h5555_5555);
		send_word(CMD_PUSH, 10'h155, 31'h2AAA_AAAA);
		send_word(CMD_REMOVE, 10'd1023, '0);
		send_word(CMD_REMOVE, 10'h155, '0);
		send_word(CMD_REMOVE, 10'd0, '0);
		send_word(CMD_POP, 10'd0, '0);
		send_word(CMD_POP, 10'd0, '0);
		send_word(CMD_PUSH, 10'd3, QTY_MAX);
		send_word(CMD_PUSH, 10'd4, 31'd1);
		send_word(CMD_REDUCE, 10'd3, QTY_MAX - 31'd1);
		send_word(CMD_POP, 10'd0, '0);
		send_word(CMD_REMOVE, 10'd3, '0);

		// random phases: each picks a command mix, a slot window and its gap style
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % PHASE_WORDS == 0) begin
				phase_mode = $urandom_range(MODE_GROW, MODE_DEEP);
				quiet_phase = ($urandom_range(0, 3) == 0);
				window_base = $urandom_range(0, OPL_ORDER_SLOTS - 1);
				window_span = (phase_mode == MODE_DEEP) ? OPL_ORDER_SLOTS
					: $urandom_range(8, 128);
			end
			send_word(pick_command(), pick_slot(), pick_qty());
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: files.f
src/opl_pkg.sv
src/opl_ram.sv
src/order_price_level_fifo.sv
tb/opl_level_checker.sv
tb/tb_top.sv
